### hw/rtl/sha_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_HASH,
        ST_EMIT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic       buf_wr;      // write one byte into the block buffer
        logic [1:0] buf_src;     // byte source select
        logic       cnt_add;     // add 8 to the bit count
        logic       hash_start;  // load working vars and start rounds
        logic       msg_clear;   // restore initial chain, clear count
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [5:0] fill;
        logic       hash_busy;
        logic       hash_done;
    } t_status;

    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hw/rtl/sha_datapath.sv
// Datapath: block buffer, bit count, message schedule, round engine, chain state.
module sha_datapath import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [2:0]  i_word_sel,
    output t_status     o_status,
    output logic [31:0] o_word
);
    logic [31:0] r_buf [16];     // block buffer, big-endian words
    logic [5:0]  r_fill;
    logic [63:0] r_cnt;
    logic [63:0] r_len;          // length latched at start of padding
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];       // rolling schedule window
    logic [6:0]  r_rnd;
    logic        r_busy;
    logic        r_done;
    logic [7:0]  wr_byte;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, ch, maj, bs0, bs1;
    logic [2:0]  len_sel;

    assign len_sel = 3'(r_fill - LEN_POS);

    always_comb begin
        case (i_cmd.buf_src)
            SRC_DATA: wr_byte = i_data_byte;
            SRC_PAD:  wr_byte = PAD_BYTE;
            SRC_ZERO: wr_byte = 8'h00;
            SRC_LEN:  wr_byte = r_len[{~len_sel, 3'd0} +: 8];
            default:  wr_byte = 8'h00;
        endcase
    end

    // Schedule: first 16 rounds read the buffer, then expand in the window.
    assign s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = s1 + r_w[9] + s0 + r_w[0];
    assign w_cur = (r_rnd < 7'd16) ? r_buf[r_rnd[3:0]] : w_new;
    assign bs1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign bs0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + bs1 + ch + ROUND_K[r_rnd[5:0]] + w_cur;
    assign t2  = bs0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_wr) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'd0} +: 8] <= wr_byte;
        end
        if (i_cmd.buf_src == SRC_PAD && i_cmd.buf_wr) begin
            r_len <= r_cnt;
        end
        if (i_cmd.hash_start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_busy) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
            r_rnd  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
        end else begin
            r_done <= 1'b0;
            if (i_cmd.buf_wr) r_fill <= r_fill + 6'd1;
            if (i_cmd.cnt_add) r_cnt <= r_cnt + 64'd8;
            if (i_cmd.hash_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 7'd1;
                if (r_rnd == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            // Fold working vars into chain in the cycle after the last round.
            if (r_done) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.msg_clear) begin
                r_cnt  <= '0;
                r_fill <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
            end
        end
    end

    assign o_status = '{fill: r_fill, hash_busy: r_busy, hash_done: r_done};
    assign o_word   = r_h[i_word_sel];

    a_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && i_cmd.buf_wr))
        else $error("buffer written during compression");
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rnd < 7'd64))
        else $error("round counter out of range");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while busy");
endmodule

### hw/rtl/sha_ctrl.sv
// Controller: sequences byte intake, padding, compressions and digest output.
module sha_ctrl import sha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_byte_valid,
    input  logic       i_eom,
    input  logic       i_out_ready,
    input  t_status    i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output logic [2:0] o_word_sel,
    output t_cmd       o_cmd
);
    t_state     r_state, n_state;
    t_state     r_ret, n_ret;        // state to resume after a compression
    logic [2:0] r_idx, n_idx;
    logic       take;

    assign take = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    if (i_byte_valid && i_status.fill == 6'd63) begin
                        n_state = ST_HASH;
                        n_ret   = i_eom ? ST_PAD : ST_IDLE;
                    end else if (i_eom) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // Pad byte landing just before the length field: go straight to it.
                if (i_status.fill == 6'd55) begin
                    n_state = ST_LEN;
                end else if (i_status.fill == 6'd63) begin
                    n_state = ST_HASH;
                    n_ret   = ST_ZERO;
                end else begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (i_status.fill == 6'd55) n_state = ST_LEN;
                else if (i_status.fill == 6'd63) begin
                    n_state = ST_HASH;
                    n_ret   = ST_ZERO;
                end
            end
            ST_LEN: begin
                if (i_status.fill == 6'd63) begin
                    n_state = ST_HASH;
                    n_ret   = ST_EMIT;
                end
            end
            ST_HASH: begin
                if (i_status.hash_done) n_state = r_ret;
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (take && i_byte_valid) begin
                    o_cmd.buf_wr  = 1'b1;
                    o_cmd.buf_src = SRC_DATA;
                    o_cmd.cnt_add = 1'b1;
                    if (i_status.fill == 6'd63) o_cmd.hash_start = 1'b1;
                end
            end
            ST_PAD: begin
                o_cmd.buf_wr  = 1'b1;
                o_cmd.buf_src = SRC_PAD;
                if (i_status.fill == 6'd63) o_cmd.hash_start = 1'b1;
            end
            ST_ZERO: begin
                o_cmd.buf_wr  = 1'b1;
                o_cmd.buf_src = SRC_ZERO;
                if (i_status.fill == 6'd63) o_cmd.hash_start = 1'b1;
            end
            ST_LEN: begin
                o_cmd.buf_wr  = 1'b1;
                o_cmd.buf_src = SRC_LEN;
                if (i_status.fill == 6'd63) o_cmd.hash_start = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready && r_idx == 3'd7) o_cmd.msg_clear = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
        end
    end

    assign o_word_sel = r_idx;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input taken while digest is out");
    a_idx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EMIT) |-> (r_idx == 3'd0))
        else $error("word index not cleared outside output");
endmodule

### hw/rtl/sha256_stream_hasher_top.sv
// SHA-256 byte stream hasher: top level joining controller and datapath.
// Throughput: one byte transfer per cycle while the block fills; a full block
// then stalls input while its 64 rounds run, one per cycle, and the fold follows.
// After the end transfer the pad, zero and length bytes are written and one or
// two compressions run before the first digest word is valid.
// Reset (i_rst_n low, synchronous) restores the initial chain and clears counts.
module sha256_stream_hasher_top import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);
    t_cmd       cmd;
    t_status    status;
    logic [2:0] word_sel;

    // Sequence intake, padding and output.
    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser),
        .i_eom        (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_status     (status),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_word_sel   (word_sel),
        .o_cmd        (cmd)
    );

    // Hold buffer, count, chain and round engine.
    sha_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (s_axis_tdata),
        .i_word_sel  (word_sel),
        .o_status    (status),
        .o_word      (m_axis_tdata)
    );

    assign m_axis_tuser = word_sel;
    assign m_axis_tlast = (word_sel == 3'd7);
endmodule
